// ===== rtl/amfp_pkg.sv =====
// Package for the serial metric frame parser: widths, byte codes, phase type,
// byte classification struct and the classify function. No dependencies.
package amfp_pkg;

	localparam int unsigned BYTE_W      = 8;
	localparam int unsigned CFG_W       = 6;
	localparam int unsigned VALUE_W     = 32;
	localparam int unsigned KIND_W      = 2;
	localparam int unsigned TDATA_W     = 5 * VALUE_W;
	localparam int unsigned TUSER_W     = 1 + KIND_W;
	localparam int unsigned MAX_PAYLOAD_DEF = 32;

	localparam logic [CFG_W-1:0] CFG_RESET = 6'd32;

	localparam logic [BYTE_W-1:0] MARK_DATA = 8'hF1;
	localparam logic [BYTE_W-1:0] MARK_NAK  = 8'hF3;
	localparam logic [BYTE_W-1:0] END_BYTE  = 8'hF6;
	localparam logic [BYTE_W-1:0] CHAR_0    = 8'h30;
	localparam logic [BYTE_W-1:0] CHAR_9    = 8'h39;
	localparam logic [BYTE_W-1:0] CHAR_A    = 8'h41;
	localparam logic [BYTE_W-1:0] CHAR_D    = 8'h44;
	localparam logic [BYTE_W-1:0] CHAR_I    = 8'h49;

	localparam logic [KIND_W-1:0] KIND_CADENCE = 2'd0;
	localparam logic [KIND_W-1:0] KIND_POWER   = 2'd1;
	localparam logic [KIND_W-1:0] KIND_RESIST  = 2'd2;

	localparam logic EV_METRIC = 1'b0;
	localparam logic EV_NAK    = 1'b1;

	typedef enum logic [2:0] {
		PH_HUNT,
		PH_TYPE,
		PH_LEN,
		PH_DATA,
		PH_SUM,
		PH_END
	} phase_t;

	typedef struct packed {
		logic              mark_data;
		logic              mark_nak;
		logic              is_end;
		logic              is_digit;
		logic [3:0]        digit;
		logic              type_ok;
		logic [KIND_W-1:0] kind;
	} cls_t;

	typedef struct packed {
		logic [BYTE_W-1:0] data;
		cls_t              cls;
	} entry_t;

	function automatic cls_t classify(input logic [BYTE_W-1:0] b);
		cls_t              c;
		logic [BYTE_W-1:0] diff;
		diff        = b - CHAR_0;
		c.mark_data = (b == MARK_DATA);
		c.mark_nak  = (b == MARK_NAK);
		c.is_end    = (b == END_BYTE);
		c.is_digit  = (b >= CHAR_0) && (b <= CHAR_9);
		c.digit     = diff[3:0];
		c.type_ok   = (b == CHAR_A) || (b == CHAR_D) || (b == CHAR_I);
		if (b == CHAR_D) begin
			c.kind = KIND_POWER;
		end else if (b == CHAR_I) begin
			c.kind = KIND_RESIST;
		end else begin
			c.kind = KIND_CADENCE;
		end
		return c;
	endfunction

endpackage

// ===== rtl/amfp_front.sv =====
// Front end: accepts received bytes, classifies them and holds them in a
// two-entry queue for the back end. Depends on amfp_pkg.
module amfp_front import amfp_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [BYTE_W-1:0] in_data,
	output logic              q_valid,
	input  logic              q_pop,
	output entry_t            q_entry
);

	entry_t     slot0_q;
	entry_t     slot1_q;
	logic [1:0] cnt_q;
	entry_t     new_entry;
	logic       push;

	assign in_ready      = (cnt_q != 2'd2);
	assign push          = in_valid && in_ready;
	assign new_entry.data = in_data;
	assign new_entry.cls  = classify(in_data);
	assign q_valid       = (cnt_q != 2'd0);
	assign q_entry       = slot0_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else begin
			if (push && !q_pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (!push && q_pop) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			slot0_q <= (push && cnt_q == 2'd1) ? new_entry : slot1_q;
			if (push && cnt_q == 2'd2) begin
				slot1_q <= new_entry;
			end
		end else if (push) begin
			if (cnt_q == 2'd0) begin
				slot0_q <= new_entry;
			end else begin
				slot1_q <= new_entry;
			end
		end
	end

endmodule

// ===== rtl/amfp_back.sv =====
// Back end: frame state machine, checksum, digit decoding with saturation,
// metric registers and the output register. Depends on amfp_pkg.
module amfp_back import amfp_pkg::*; #(
	parameter int unsigned MAX_PAYLOAD = MAX_PAYLOAD_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [CFG_W-1:0]   cfg_wdata,
	input  logic               q_valid,
	output logic               q_pop,
	input  entry_t             q_entry,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [TDATA_W-1:0] out_data,
	output logic [TUSER_W-1:0] out_user
);

	localparam logic [CFG_W-1:0] MAX_LIM = CFG_W'(MAX_PAYLOAD);

	logic [CFG_W-1:0]   cfg_q;
	phase_t             phase_q, phase_d;
	logic               nak_q, nak_d;
	cls_t               held_cls_q, held_cls_d;
	logic [CFG_W-1:0]   len_q, len_d;
	logic [CFG_W-1:0]   seen_q, seen_d;
	logic [BYTE_W-1:0]  sum_q, sum_d;
	logic               dok_q, dok_d;
	logic               chk_q, chk_d;
	logic [VALUE_W-1:0] acc_q, acc_d;
	logic [VALUE_W-1:0] w_q, w_d;
	logic               wovf_q, wovf_d;
	logic [VALUE_W-1:0] cad_q, cad_d;
	logic [VALUE_W-1:0] pwr_q, pwr_d;
	logic [VALUE_W-1:0] res_q, res_d;
	logic [VALUE_W-1:0] cnt_q, cnt_d;

	logic               ovalid_q;
	logic [TDATA_W-1:0] odata_q;
	logic [TUSER_W-1:0] ouser_q;

	logic               emit;
	logic               ev;
	logic [KIND_W-1:0]  okind;
	logic [VALUE_W-1:0] oval;

	logic [BYTE_W-1:0]  b;
	cls_t               c;
	logic [CFG_W-1:0]   lim;
	logic [CFG_W-1:0]   seen_inc;
	logic [35:0]        prod;
	logic [35:0]        acc_sum;
	logic [35:0]        w10;
	logic               frame_ok;

	assign b        = q_entry.data;
	assign c        = q_entry.cls;
	assign lim      = (cfg_q > MAX_LIM) ? MAX_LIM : cfg_q;
	assign seen_inc = seen_q + CFG_W'(1);
	assign prod     = 36'(w_q) * 36'(c.digit);
	assign acc_sum  = 36'(acc_q) + prod;
	assign w10      = {1'b0, w_q, 3'b000} + {3'b000, w_q, 1'b0};
	assign frame_ok = c.is_end && chk_q && (len_q != '0) && dok_q && held_cls_q.type_ok;

	assign q_pop     = q_valid && (!ovalid_q || out_ready);
	assign out_valid = ovalid_q;
	assign out_data  = odata_q;
	assign out_user  = ouser_q;

	always_comb begin
		phase_d    = phase_q;
		nak_d      = nak_q;
		held_cls_d = held_cls_q;
		len_d      = len_q;
		seen_d     = seen_q;
		sum_d      = sum_q;
		dok_d      = dok_q;
		chk_d      = chk_q;
		acc_d      = acc_q;
		w_d        = w_q;
		wovf_d     = wovf_q;
		cad_d      = cad_q;
		pwr_d      = pwr_q;
		res_d      = res_q;
		cnt_d      = cnt_q;
		emit       = 1'b0;
		ev         = EV_METRIC;
		okind      = KIND_CADENCE;
		oval       = '0;
		if (q_pop) begin
			unique case (phase_q)
				PH_HUNT: begin
					if (c.mark_data || c.mark_nak) begin
						phase_d    = PH_TYPE;
						nak_d      = c.mark_nak;
						held_cls_d = '0;
						len_d      = '0;
						seen_d     = '0;
						sum_d      = b;
						dok_d      = 1'b1;
						chk_d      = 1'b0;
						acc_d      = '0;
						w_d        = VALUE_W'(1);
						wovf_d     = 1'b0;
					end
				end
				PH_TYPE: begin
					held_cls_d = c;
					sum_d      = sum_q + b;
					phase_d    = PH_LEN;
				end
				PH_LEN: begin
					priority if (nak_q) begin
						phase_d = PH_SUM;
					end else if (b > {2'b00, lim}) begin
						// length implausible: rescan held type byte, then this byte
						priority if (held_cls_q.mark_data || held_cls_q.mark_nak) begin
							phase_d    = PH_LEN;
							nak_d      = held_cls_q.mark_nak;
							held_cls_d = c;
							sum_d      = (held_cls_q.mark_nak ? MARK_NAK : MARK_DATA) + b;
						end else if (c.mark_data || c.mark_nak) begin
							phase_d    = PH_TYPE;
							nak_d      = c.mark_nak;
							held_cls_d = '0;
							sum_d      = b;
						end else begin
							phase_d    = PH_HUNT;
						end
						if (held_cls_q.mark_data || held_cls_q.mark_nak
							|| c.mark_data || c.mark_nak) begin
							len_d  = '0;
							seen_d = '0;
							dok_d  = 1'b1;
							chk_d  = 1'b0;
							acc_d  = '0;
							w_d    = VALUE_W'(1);
							wovf_d = 1'b0;
						end
					end else begin
						len_d   = b[CFG_W-1:0];
						sum_d   = sum_q + b;
						phase_d = (b == '0) ? PH_SUM : PH_DATA;
					end
				end
				PH_DATA: begin
					sum_d = sum_q + b;
					if (!c.is_digit) begin
						dok_d = 1'b0;
					end else if (dok_q) begin
						if (c.digit != 4'd0) begin
							if (wovf_q || (acc_sum[35:32] != 4'd0)) begin
								acc_d = '1;
							end else begin
								acc_d = acc_sum[VALUE_W-1:0];
							end
						end
						if (!wovf_q) begin
							if (w10[35:32] != 4'd0) begin
								wovf_d = 1'b1;
							end else begin
								w_d = w10[VALUE_W-1:0];
							end
						end
					end
					seen_d = seen_inc;
					if (seen_inc >= len_q) begin
						phase_d = PH_SUM;
					end
				end
				PH_SUM: begin
					chk_d   = (b == sum_q);
					phase_d = PH_END;
				end
				PH_END: begin
					phase_d = PH_HUNT;
					if (nak_q) begin
						emit = 1'b1;
						ev   = EV_NAK;
					end else if (frame_ok) begin
						emit  = 1'b1;
						okind = held_cls_q.kind;
						oval  = acc_q;
						cnt_d = cnt_q + VALUE_W'(1);
						unique case (held_cls_q.kind)
							KIND_POWER:  pwr_d = acc_q;
							KIND_RESIST: res_d = acc_q;
							default:     cad_d = acc_q;
						endcase
					end
				end
				default: begin
					phase_d = PH_HUNT;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q      <= CFG_RESET;
			phase_q    <= PH_HUNT;
			nak_q      <= 1'b0;
			held_cls_q <= '0;
			len_q      <= '0;
			seen_q     <= '0;
			sum_q      <= '0;
			dok_q      <= 1'b1;
			chk_q      <= 1'b0;
			acc_q      <= '0;
			w_q        <= VALUE_W'(1);
			wovf_q     <= 1'b0;
			cad_q      <= '0;
			pwr_q      <= '0;
			res_q      <= '0;
			cnt_q      <= '0;
			ovalid_q   <= 1'b0;
		end else begin
			if (cfg_we) begin
				cfg_q <= cfg_wdata;
			end
			phase_q    <= phase_d;
			nak_q      <= nak_d;
			held_cls_q <= held_cls_d;
			len_q      <= len_d;
			seen_q     <= seen_d;
			sum_q      <= sum_d;
			dok_q      <= dok_d;
			chk_q      <= chk_d;
			acc_q      <= acc_d;
			w_q        <= w_d;
			wovf_q     <= wovf_d;
			cad_q      <= cad_d;
			pwr_q      <= pwr_d;
			res_q      <= res_d;
			cnt_q      <= cnt_d;
			if (emit) begin
				ovalid_q <= 1'b1;
			end else if (out_ready) begin
				ovalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			odata_q <= {cnt_d, res_d, pwr_d, cad_d, oval};
			ouser_q <= {okind, ev};
		end
	end

endmodule

// ===== rtl/ascii_metric_frame_parser_top.sv =====
// Top level of the serial metric frame parser: byte front end, queue, and
// frame back end. Depends on amfp_pkg, amfp_front and amfp_back.
//
//   port group  dir  fields (lsb first)
//   s_axis      in   tdata: rx_byte[7:0]
//   m_axis      out  tuser: event_kind, metric_kind[1:0]
//                    tdata: metric_value, latest_cadence, latest_power,
//                           latest_resistance, good_frame_count (32b each)
//   cfg         in   cfg_wdata: max_payload_length[5:0], written when cfg_we
//
// One byte per cycle sustained unless a result is held; the back end takes one
// queued byte each such cycle. The end byte of a good or NAK frame loads the
// output register. The two-entry queue keeps input flowing while output is held,
// until full. Back end stalls only while a result waits on m_axis_tready.
// arst_n resets all but the data registers; max_payload_length returns to 32.
module ascii_metric_frame_parser_top import amfp_pkg::*; #(
	parameter int unsigned MAX_PAYLOAD = MAX_PAYLOAD_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_axis_tvalid,
	output logic               s_axis_tready,
	input  logic [BYTE_W-1:0]  s_axis_tdata,  // rx_byte
	output logic               m_axis_tvalid,
	input  logic               m_axis_tready,
	// metric_value, latest_cadence, latest_power, latest_resistance, good_frame_count
	output logic [TDATA_W-1:0] m_axis_tdata,
	output logic [TUSER_W-1:0] m_axis_tuser,  // event_kind, metric_kind
	input  logic               cfg_we,
	input  logic [CFG_W-1:0]   cfg_wdata      // max_payload_length
);

	logic   q_valid;
	logic   q_pop;
	entry_t q_entry;

	amfp_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.in_data  (s_axis_tdata),
		.q_valid  (q_valid),
		.q_pop    (q_pop),
		.q_entry  (q_entry)
	);

	amfp_back #(
		.MAX_PAYLOAD (MAX_PAYLOAD)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.q_valid   (q_valid),
		.q_pop     (q_pop),
		.q_entry   (q_entry),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (m_axis_tdata),
		.out_user  (m_axis_tuser)
	);

	a_pop_has_data: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_valid)
		else $error("queue popped while empty");

	a_no_pop_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |-> !q_pop)
		else $error("back end advanced while result stalled");

	a_full_means_data: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> q_valid)
		else $error("input blocked with empty queue");

	a_nak_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tuser[0]) |->
			(m_axis_tdata[31:0] == 32'd0) && (m_axis_tuser[2:1] == 2'd0))
		else $error("NAK result carries metric data");

endmodule
